FILE: design/psf_pkg.sv
// Shared types, constants and a helper function for the palette store fade block.
`timescale 1ns / 1ps
package psf_pkg;
    localparam int CAPACITY_DEF        = 256;
    localparam int FULL_SHADES_DEF     = 16;
    localparam int WHITEOUT_SHADES_DEF = 32;
    localparam int BANK_DEPTH          = 256;
    localparam int IDX_W               = 8;
    localparam int CNT_W               = 9;
    localparam int RGB_W               = 24;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_FIND  = 2'd1,
        OP_FADE  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NONE  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    localparam logic [1:0] REG_DARK_SELECT = 2'd0;
    localparam logic [1:0] REG_WHITEOUT_EN = 2'd1;
    localparam logic [1:0] REG_FADE_BYPASS = 2'd2;

    // Item held in the queue between the front and back parts.
    typedef struct packed {
        op_t                op;
        logic [RGB_W-1:0]   rgb;
        logic [IDX_W-1:0]   idx;
        logic               bank;
        logic [5:0]         amt;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [IDX_W-1:0]   ridx;
        logic [RGB_W-1:0]   rgb;
    } res_t;

    function automatic logic [7:0] sat8(input logic [13:0] v);
        return (v > 14'd255) ? 8'hff : v[7:0];
    endfunction
endpackage

FILE: design/palette_store_fade_unit.sv
// Top level of the palette store fade block.
// Items enter on the s_ channel (valid/ready) and land in a two-entry queue,
// so the sender keeps going while the back part works. The back part runs
// add, find, write and fade on two 256-entry banks held in single-port RAMs.
// Exactly one result item leaves on the m_ channel for each input item.
// Add and write go straight to the registered result, fade goes through one
// registered RAM read, and find walks the selected bank one entry a cycle
// until it finds a match or passes the last entry. The back part holds one
// item at a time, so it takes no new item until the result of the last has
// been taken by the receiver.
// Configuration writes go through cfg_valid/cfg_ready with cfg_index and
// cfg_data; they are taken at any time and must only arrive while idle.
// Reset clears the entry count, configuration registers and queue; bank
// contents are undefined until added. A stalled receiver holds the result
// and the queue fills, after which s_ready falls.
`timescale 1ns / 1ps
module palette_store_fade_unit #(
    parameter int CAPACITY        = psf_pkg::CAPACITY_DEF,
    parameter int FULL_SHADES     = psf_pkg::FULL_SHADES_DEF,
    parameter int WHITEOUT_SHADES = psf_pkg::WHITEOUT_SHADES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [7:0] s_red_in,
    input  logic [7:0] s_green_in,
    input  logic [7:0] s_blue_in,
    input  logic [7:0] s_entry_index,
    input  logic       s_bank_in,
    input  logic [5:0] s_fade_amount,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [7:0] m_result_index,
    output logic [7:0] m_red_out,
    output logic [7:0] m_green_out,
    output logic [7:0] m_blue_out,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic       cfg_data
);
    import psf_pkg::*;

    cmd_t s_cmd, q_cmd;
    res_t res;
    logic q_valid, q_ready;
    logic dark_select_reg, whiteout_en_reg, fade_bypass_reg;

    assign cfg_ready = 1'b1;
    assign s_cmd = '{op: op_t'(s_opcode), rgb: {s_red_in, s_green_in, s_blue_in},
                     idx: s_entry_index, bank: s_bank_in, amt: s_fade_amount};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_select_reg <= 1'b0;
            whiteout_en_reg <= 1'b0;
            fade_bypass_reg <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == REG_DARK_SELECT) dark_select_reg <= cfg_data;
            if (cfg_index == REG_WHITEOUT_EN) whiteout_en_reg <= cfg_data;
            if (cfg_index == REG_FADE_BYPASS) fade_bypass_reg <= cfg_data;
        end
    end

    psf_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_cmd(s_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd));

    psf_back #(
        .CAPACITY(CAPACITY), .FULL_SHADES(FULL_SHADES),
        .WHITEOUT_SHADES(WHITEOUT_SHADES)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd), .dark_select(dark_select_reg), .whiteout_en(whiteout_en_reg),
        .fade_bypass(fade_bypass_reg), .m_valid(m_valid), .m_ready(m_ready),
        .m_res(res));

    assign m_status       = res.status;
    assign m_result_index = res.ridx;
    assign m_red_out      = res.rgb[23:16];
    assign m_green_out    = res.rgb[15:8];
    assign m_blue_out     = res.rgb[7:0];
endmodule

FILE: design/psf_ram.sv
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
module psf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: design/psf_front.sv
// Front part: accepts items and places them in a two-entry queue.
`timescale 1ns / 1ps
module psf_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  psf_pkg::cmd_t s_cmd,
    output logic          q_valid,
    input  logic          q_ready,
    output psf_pkg::cmd_t q_cmd
);
    import psf_pkg::*;

    cmd_t       buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = buf_reg[rd_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_reg <= ~wr_reg;
            end
            if (pop) begin
                rd_reg <= ~rd_reg;
            end
        end
        if (push) begin
            buf_reg[wr_reg] <= s_cmd;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !s_ready) else $error("queue overfilled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 && push) |=> q_valid) else $error("item lost in queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
endmodule

FILE: design/psf_back.sv
// Back part: carries out add, find, write and fade against the two banks.
`timescale 1ns / 1ps
module psf_back #(
    parameter int CAPACITY        = psf_pkg::CAPACITY_DEF,
    parameter int FULL_SHADES     = psf_pkg::FULL_SHADES_DEF,
    parameter int WHITEOUT_SHADES = psf_pkg::WHITEOUT_SHADES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  psf_pkg::cmd_t q_cmd,
    input  logic          dark_select,
    input  logic          whiteout_en,
    input  logic          fade_bypass,
    output logic          m_valid,
    input  logic          m_ready,
    output psf_pkg::res_t m_res
);
    import psf_pkg::*;

    localparam int DIFF = WHITEOUT_SHADES - FULL_SHADES;
    localparam int GREY_RAW = (DIFF > 0) ? (255 / DIFF) : 255;
    localparam logic [7:0] GREY_STEP = 8'(GREY_RAW);
    localparam logic [6:0] DIFF_W = 7'((DIFF > 0) ? DIFF : 0);
    localparam logic [CNT_W-1:0] CAP_W = CNT_W'(CAPACITY);
    localparam logic [5:0] FULL_W = 6'(FULL_SHADES);
    // Division of a channel by FULL_SHADES as a multiply by a rounded-up
    // reciprocal; exact for every 8-bit channel value.
    localparam int RSH = 8 + $clog2(FULL_SHADES);
    localparam int RECIP = ((1 << RSH) + FULL_SHADES - 1) / FULL_SHADES;
    localparam logic [8:0] RECIP_W = 9'(RECIP);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_OUT} state_t;

    state_t           state_reg;
    cmd_t             cmd_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] scan_reg;
    logic             scan_live_reg;
    logic [IDX_W-1:0] scan_idx_reg;
    res_t             res_reg, res_next;
    logic             m_valid_reg, m_valid_next;

    logic             nb_we, db_we;
    logic [IDX_W-1:0] addr;
    logic [RGB_W-1:0] nb_wdata, db_wdata, nb_rdata, db_rdata, sel_rdata;
    logic             take;
    logic             idx_range;
    logic             scan_more, scan_hit, scan_done;

    assign m_valid = m_valid_reg;
    assign m_res   = res_reg;
    assign q_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign take    = q_valid && q_ready;
    assign sel_rdata = dark_select ? db_rdata : nb_rdata;
    assign idx_range = ({1'b0, q_cmd.idx} >= count_reg);
    assign scan_more = (scan_reg < count_reg) && !scan_reg[CNT_W-1];
    assign scan_hit  = scan_live_reg && (sel_rdata == cmd_reg.rgb);
    assign scan_done = scan_hit || !scan_more;

    always_comb begin
        nb_we    = 1'b0;
        db_we    = 1'b0;
        addr     = q_cmd.idx;
        nb_wdata = q_cmd.rgb;
        db_wdata = q_cmd.rgb;
        if (state_reg == S_SCAN) begin
            addr = scan_reg[IDX_W-1:0];
        end else if (take) begin
            unique case (q_cmd.op)
                OP_ADD: begin
                    addr  = count_reg[IDX_W-1:0];
                    nb_we = (count_reg < CAP_W) && !count_reg[CNT_W-1];
                    db_we = nb_we;
                end
                OP_WRITE: begin
                    nb_we = ({1'b0, q_cmd.idx} < count_reg) && !q_cmd.bank;
                    db_we = ({1'b0, q_cmd.idx} < count_reg) && q_cmd.bank;
                end
                default: ;
            endcase
        end
    end

    psf_ram #(.WIDTH(RGB_W), .DEPTH(BANK_DEPTH)) u_normal (
        .aclk(aclk), .we(nb_we), .addr(addr), .wdata(nb_wdata), .rdata(nb_rdata));
    psf_ram #(.WIDTH(RGB_W), .DEPTH(BANK_DEPTH)) u_dark (
        .aclk(aclk), .we(db_we), .addr(addr), .wdata(db_wdata), .rdata(db_rdata));

    // Fade arithmetic on the registered bank read.
    logic [5:0]  amt_eff;
    logic [7:0]  grey;
    logic [13:0] grey_prod;
    logic [RGB_W-1:0] faded;
    logic [7:0]  ch [3];
    logic [16:0] rprod [3];
    logic [7:0]  q [3];
    logic [13:0] prod [3];

    always_comb begin
        amt_eff = fade_bypass ? FULL_W : cmd_reg.amt;
        if (DIFF > 0) begin
            grey_prod = 14'(GREY_STEP * 7'({1'b0, amt_eff} - DIFF_W));
        end else begin
            grey_prod = 14'd0;
        end
        if (DIFF <= 0) begin
            grey = 8'hff;
        end else if ({1'b0, amt_eff} < DIFF_W) begin
            grey = 8'h00;
        end else begin
            grey = sat8(grey_prod);
        end
        ch[0] = sel_rdata[23:16];
        ch[1] = sel_rdata[15:8];
        ch[2] = sel_rdata[7:0];
        for (int k = 0; k < 3; k++) begin
            rprod[k] = 17'(ch[k] * RECIP_W);
            q[k] = 8'(rprod[k] >> RSH);
            prod[k] = 14'(q[k] * amt_eff);
        end
        if (amt_eff == FULL_W) begin
            faded = sel_rdata;
        end else if ((cmd_reg.idx == 8'd0 || cmd_reg.idx == 8'd16) && whiteout_en
                     && amt_eff > FULL_W) begin
            faded = {grey, grey, grey};
        end else begin
            faded = {sat8(prod[0]), sat8(prod[1]), sat8(prod[2])};
        end
    end

    always_comb begin
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (take) begin
                    res_next = '{status: ST_OK, ridx: '0, rgb: '0};
                    unique case (q_cmd.op)
                        OP_ADD: begin
                            if (nb_we) begin
                                res_next.ridx = count_reg[IDX_W-1:0];
                            end else begin
                                res_next.status = ST_FULL;
                            end
                            m_valid_next = 1'b1;
                        end
                        OP_WRITE: begin
                            if (idx_range) begin
                                res_next.status = ST_RANGE;
                            end
                            m_valid_next = 1'b1;
                        end
                        OP_FADE: begin
                            if (idx_range) begin
                                res_next.status = ST_RANGE;
                                m_valid_next    = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                // The compare looks at the entry read in the previous cycle.
                if (scan_hit) begin
                    res_next.ridx = scan_idx_reg;
                    m_valid_next  = 1'b1;
                end else if (!scan_more) begin
                    res_next.status = ST_NONE;
                    m_valid_next    = 1'b1;
                end
            end
            S_READ: begin
                res_next.rgb = faded;
                m_valid_next = 1'b1;
            end
            S_OUT: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            res_reg     <= res_next;
            unique case (state_reg)
                S_IDLE: begin
                    if (take) begin
                        cmd_reg <= q_cmd;
                        unique case (q_cmd.op)
                            OP_ADD: begin
                                if (nb_we) begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            OP_FIND: begin
                                scan_reg      <= '0;
                                scan_live_reg <= 1'b0;
                                state_reg     <= S_SCAN;
                            end
                            OP_FADE: begin
                                if (!idx_range) begin
                                    state_reg <= S_READ;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    // One entry read per cycle.
                    scan_live_reg <= scan_more;
                    scan_idx_reg  <= scan_reg[IDX_W-1:0];
                    scan_reg      <= scan_reg + 1'b1;
                    if (scan_done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_READ: begin
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_W) else $error("entry count beyond capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(res_reg)) else $error("result changed");
    assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> !m_valid_reg) else $error("item taken over pending result");
endmodule
